// ===== rtl/core/i2cra_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cra_pkg: shared types and constants for the i2c register access master
// Item, command kind, bus phase and result types used by front, queue and
// engine.
// ----------------------------------------------------------------------------
package i2cra_pkg;

  // stream widths
  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 16;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 8;

  // queue between front and engine
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // register reset values
  localparam logic [7:0] DEV_ADDR_RST  = 8'd208;
  localparam logic [7:0] ACK_LIMIT_RST = 8'd200;

  // raw func codes on the input channel
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_DEV_ADDR  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ACK_LIMIT = 2'd1;

  // byte slots within one transfer
  localparam logic [1:0] BYTE_DEV  = 2'd0;
  localparam logic [1:0] BYTE_REG  = 2'd1;
  localparam logic [1:0] BYTE_LAST = 2'd2;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef struct packed {
    cmd_t       kind;
    logic [7:0] reg_addr;
    logic [7:0] write_value;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic [7:0] read_value;
    logic       status;
    logic       done_res;
    logic       busy_res;
    logic       sda_level;
    logic       sda_drive;
    logic       scl_level;
  } res_t;

  typedef enum logic [15:0] {
    PH_IDLE     = 16'h0001,
    PH_START_H  = 16'h0002,
    PH_START_L  = 16'h0004,
    PH_BIT_L    = 16'h0008,
    PH_BIT_H    = 16'h0010,
    PH_ACK_L    = 16'h0020,
    PH_ACK_H    = 16'h0040,
    PH_RS_L     = 16'h0080,
    PH_RS_H     = 16'h0100,
    PH_RD_L     = 16'h0200,
    PH_RD_H     = 16'h0400,
    PH_NACK_L   = 16'h0800,
    PH_NACK_H   = 16'h1000,
    PH_STOP_L   = 16'h2000,
    PH_STOP_H   = 16'h4000,
    PH_STOP_END = 16'h8000
  } phase_t;

endpackage

// ===== rtl/core/i2c_register_access_master.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_register_access_master: clocked i2c master for single-register access
// Each input transaction is one half-bit tick; each tick yields one result
// with the scl/sda levels and transaction status.
// ----------------------------------------------------------------------------
//  channel  | ports                       | contents
//  ---------+-----------------------------+----------------------------------
//  input    | in_tvalid/tready/tdata/tuser| one tick, func and sampled sda
//  result   | out_tvalid/tready/tdata     | bus levels, busy, done, status
//  config   | cfg_we/cfg_addr/cfg_wdata   | device address, ack wait limit
//
// one tick is accepted per clock while the queue has room and yields one
// result; it passes through the four-entry queue and the result register.
// the sequencer steps one phase per tick.
// reset (rst_n low, synchronous) empties the queue and puts the bus idle.
// a stalled result side fills the queue, then in_tready drops.
// ----------------------------------------------------------------------------
module i2c_register_access_master (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // reg_addr[7:0], write_value[15:8], sda_in[16], zero pad
  input  logic [i2cra_pkg::IN_TDATA_W-1:0]  in_tdata,
  // func[1:0]
  input  logic [i2cra_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // scl_level[0], sda_drive[1], sda_level[2], busy_res[3], done_res[4],
  // status[5], read_value[13:6], zero pad
  output logic [i2cra_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                              cfg_we,
  input  logic [i2cra_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [i2cra_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import i2cra_pkg::*;

  logic       push;
  item_t      push_item;
  logic       q_full;
  logic       pop;
  logic       q_valid;
  item_t      head;
  res_t       res;
  logic [7:0] dev_addr_r;
  logic [7:0] ack_limit_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r  <= DEV_ADDR_RST;
      ack_limit_r <= ACK_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_DEV_ADDR:  dev_addr_r  <= cfg_wdata;
        CFG_ACK_LIMIT: ack_limit_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  i2cra_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full)
  );

  i2cra_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .head      (head)
  );

  i2cra_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .head      (head),
    .pop       (pop),
    .dev_addr  (dev_addr_r),
    .ack_limit (ack_limit_r),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .res       (res)
  );

  // pack the result fields, lowest first
  assign out_tdata = {2'b00, res.read_value, res.status, res.done_res, res.busy_res,
                      res.sda_level, res.sda_drive, res.scl_level};

endmodule

// ===== rtl/core/i2cra_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cra_front: input side of the i2c register access master
// Unpacks incoming ticks, classifies the func code into a command kind and
// pushes the item into the queue while there is room.
// ----------------------------------------------------------------------------
module i2cra_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [i2cra_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic [i2cra_pkg::IN_TUSER_W-1:0] in_tuser,
  output logic                             push,
  output i2cra_pkg::item_t                 push_item,
  input  logic                             q_full
);
  import i2cra_pkg::*;

  cmd_t kind;

  // classify func, unused code counts as a plain tick
  always_comb begin
    case (in_tuser)
      FUNC_WRITE: kind = CMD_WRITE;
      FUNC_READ:  kind = CMD_READ;
      default:    kind = CMD_TICK;
    endcase
  end

  // accept whenever the queue has room
  assign in_tready             = ~q_full;
  assign push                  = in_tvalid & ~q_full;
  assign push_item.kind        = kind;
  assign push_item.reg_addr    = in_tdata[7:0];
  assign push_item.write_value = in_tdata[15:8];
  assign push_item.sda_in      = in_tdata[16];

`ifndef ASSERT_OFF
  // a transaction is only pushed when the queue has space
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !push) else $error("push while queue full");
`endif

endmodule

// ===== rtl/core/i2cra_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cra_queue: short fifo between front and engine
// Holds classified ticks so the input and result sides stall independently.
// ----------------------------------------------------------------------------
module i2cra_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  i2cra_pkg::item_t push_item,
  output logic             full,
  input  logic             pop,
  output logic             q_valid,
  output i2cra_pkg::item_t head
);
  import i2cra_pkg::*;

  item_t                  slot_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CNT_W-1:0] count_r, count_nxt;
  logic                   do_pop;

  assign full    = (count_r == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign head    = slot_r[rd_ptr_r];
  assign do_pop  = pop & q_valid;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // payload storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

`ifndef ASSERT_OFF
  // fill count never passes the depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QUEUE_CNT_W'(QUEUE_DEPTH)) else $error("queue count overflow");
  // count rises on a push without a pop
  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !do_pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count did not advance");
`endif

endmodule

// ===== rtl/core/i2cra_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cra_engine: bus sequencer of the i2c register access master
// Takes one queued tick per cycle while the result register is free or being
// drained, steps the start/byte/ack/read/stop sequence and registers the bus
// levels and status as one result.
module i2cra_engine (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  i2cra_pkg::item_t head,
  output logic             pop,
  input  logic [7:0]       dev_addr,
  input  logic [7:0]       ack_limit,
  output logic             out_valid,
  input  logic             out_ready,
  output i2cra_pkg::res_t  res
);
  import i2cra_pkg::*;

  phase_t     phase_r, phase_nxt, cur_phase;
  logic [3:0] bit_cnt_r, bit_cnt_nxt, cur_bit_cnt, bit_cnt_inc;
  logic [7:0] shift_r, shift_nxt, cur_shift;
  logic [1:0] byte_idx_r, byte_idx_nxt, cur_byte_idx;
  logic [7:0] ack_cnt_r, ack_cnt_nxt, cur_ack_cnt;
  logic [7:0] held_reg_r, held_reg_nxt, cur_held_reg;
  logic [7:0] held_wval_r, held_wval_nxt, cur_held_wval;
  logic       is_read_r, is_read_nxt, cur_is_read;
  logic       failed_r, failed_nxt, cur_failed;
  logic [7:0] rx_byte_r, rx_byte_nxt;
  logic       out_valid_r;
  res_t       res_r, res_nxt;
  logic       cmd_start;
  logic       take;

  // take a tick when the result register is free or being drained
  assign take      = q_valid & (~out_valid_r | out_ready);
  assign pop       = take;
  assign out_valid = out_valid_r;
  assign res       = res_r;

  // command in idle loads the transfer context
  assign cmd_start   = (phase_r == PH_IDLE) && (head.kind != CMD_TICK);
  assign bit_cnt_inc = cur_bit_cnt + 4'd1;

  always_comb begin
    cur_phase     = phase_r;
    cur_bit_cnt   = bit_cnt_r;
    cur_shift     = shift_r;
    cur_byte_idx  = byte_idx_r;
    cur_ack_cnt   = ack_cnt_r;
    cur_held_reg  = held_reg_r;
    cur_held_wval = held_wval_r;
    cur_is_read   = is_read_r;
    cur_failed    = failed_r;
    if (cmd_start) begin
      cur_phase     = PH_START_H;
      cur_bit_cnt   = '0;
      cur_shift     = dev_addr;
      cur_byte_idx  = BYTE_DEV;
      cur_ack_cnt   = '0;
      cur_held_reg  = head.reg_addr;
      cur_held_wval = head.write_value;
      cur_is_read   = (head.kind == CMD_READ);
      cur_failed    = 1'b0;
    end
  end

  // one tick of the bus sequence
  always_comb begin
    phase_nxt          = cur_phase;
    bit_cnt_nxt        = cur_bit_cnt;
    shift_nxt          = cur_shift;
    byte_idx_nxt       = cur_byte_idx;
    ack_cnt_nxt        = cur_ack_cnt;
    held_reg_nxt       = cur_held_reg;
    held_wval_nxt      = cur_held_wval;
    is_read_nxt        = cur_is_read;
    failed_nxt         = cur_failed;
    rx_byte_nxt        = rx_byte_r;
    res_nxt.scl_level  = 1'b1;
    res_nxt.sda_drive  = 1'b1;
    res_nxt.sda_level  = 1'b1;
    res_nxt.busy_res   = 1'b1;
    res_nxt.done_res   = 1'b0;
    res_nxt.status     = 1'b0;
    case (cur_phase)
      PH_START_H: begin
        res_nxt.sda_level = 1'b0;
        phase_nxt         = PH_START_L;
      end
      PH_START_L: begin
        res_nxt.scl_level = 1'b0;
        res_nxt.sda_level = 1'b0;
        bit_cnt_nxt       = '0;
        phase_nxt         = PH_BIT_L;
      end
      PH_BIT_L: begin
        res_nxt.scl_level = 1'b0;
        res_nxt.sda_level = cur_shift[7];
        phase_nxt         = PH_BIT_H;
      end
      PH_BIT_H: begin
        res_nxt.sda_level = cur_shift[7];
        shift_nxt         = {cur_shift[6:0], 1'b0};
        bit_cnt_nxt       = bit_cnt_inc;
        phase_nxt         = bit_cnt_inc[3] ? PH_ACK_L : PH_BIT_L;
      end
      PH_ACK_L: begin
        res_nxt.scl_level = 1'b0;
        res_nxt.sda_drive = 1'b0;
        res_nxt.sda_level = 1'b0;
        ack_cnt_nxt       = '0;
        phase_nxt         = PH_ACK_H;
      end
      PH_ACK_H: begin
        res_nxt.sda_drive = 1'b0;
        res_nxt.sda_level = 1'b0;
        if (!head.sda_in) begin
          // acknowledged: move to the next byte or part
          case (cur_byte_idx)
            BYTE_DEV: begin
              shift_nxt    = cur_held_reg;
              byte_idx_nxt = BYTE_REG;
              bit_cnt_nxt  = '0;
              phase_nxt    = PH_BIT_L;
            end
            BYTE_REG: begin
              if (cur_is_read) begin
                phase_nxt = PH_RS_L;
              end else begin
                shift_nxt    = cur_held_wval;
                byte_idx_nxt = BYTE_LAST;
                bit_cnt_nxt  = '0;
                phase_nxt    = PH_BIT_L;
              end
            end
            default: begin
              bit_cnt_nxt = '0;
              if (cur_is_read) begin
                shift_nxt = '0;
                phase_nxt = PH_RD_L;
              end else begin
                phase_nxt = PH_STOP_L;
              end
            end
          endcase
        end else if (cur_ack_cnt >= ack_limit) begin
          failed_nxt = 1'b1;
          phase_nxt  = PH_STOP_L;
        end else begin
          ack_cnt_nxt = cur_ack_cnt + 8'd1;
        end
      end
      PH_RS_L: begin
        res_nxt.scl_level = 1'b0;
        phase_nxt         = PH_RS_H;
      end
      PH_RS_H: begin
        shift_nxt    = dev_addr + 8'd1;
        byte_idx_nxt = BYTE_LAST;
        phase_nxt    = PH_START_H;
      end
      PH_RD_L: begin
        res_nxt.scl_level = 1'b0;
        res_nxt.sda_drive = 1'b0;
        res_nxt.sda_level = 1'b0;
        phase_nxt         = PH_RD_H;
      end
      PH_RD_H: begin
        res_nxt.sda_drive = 1'b0;
        res_nxt.sda_level = 1'b0;
        shift_nxt         = {cur_shift[6:0], head.sda_in};
        bit_cnt_nxt       = bit_cnt_inc;
        phase_nxt         = bit_cnt_inc[3] ? PH_NACK_L : PH_RD_L;
      end
      PH_NACK_L: begin
        res_nxt.scl_level = 1'b0;
        phase_nxt         = PH_NACK_H;
      end
      PH_NACK_H: begin
        phase_nxt = PH_STOP_L;
      end
      PH_STOP_L: begin
        res_nxt.scl_level = 1'b0;
        res_nxt.sda_level = 1'b0;
        phase_nxt         = PH_STOP_H;
      end
      PH_STOP_H: begin
        res_nxt.sda_level = 1'b0;
        phase_nxt         = PH_STOP_END;
      end
      PH_STOP_END: begin
        res_nxt.done_res = 1'b1;
        res_nxt.status   = cur_failed;
        if (!cur_failed && cur_is_read) begin
          rx_byte_nxt = cur_shift;
        end
        phase_nxt = PH_IDLE;
      end
      default: begin
        // idle: bus released high
        res_nxt.busy_res = 1'b0;
        phase_nxt        = PH_IDLE;
      end
    endcase
    res_nxt.read_value = rx_byte_nxt;
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      bit_cnt_r   <= '0;
      shift_r     <= '0;
      byte_idx_r  <= BYTE_DEV;
      ack_cnt_r   <= '0;
      held_reg_r  <= '0;
      held_wval_r <= '0;
      is_read_r   <= 1'b0;
      failed_r    <= 1'b0;
      rx_byte_r   <= '0;
    end else if (take) begin
      phase_r     <= phase_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      shift_r     <= shift_nxt;
      byte_idx_r  <= byte_idx_nxt;
      ack_cnt_r   <= ack_cnt_nxt;
      held_reg_r  <= held_reg_nxt;
      held_wval_r <= held_wval_nxt;
      is_read_r   <= is_read_nxt;
      failed_r    <= failed_nxt;
      rx_byte_r   <= rx_byte_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_nxt;
    end
  end

`ifndef ASSERT_OFF
  // a missing-ack status only comes with done
  a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.status) |-> res_r.done_res)
    else $error("status without done");
  // done marks the last busy tick
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.done_res) |-> res_r.busy_res)
    else $error("done outside a transaction");
  // released sda reads as level zero
  a_release_low: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_r.sda_drive) |-> !res_r.sda_level)
    else $error("level set while sda released");
  // after done the sequencer is back in idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (take && res_nxt.done_res) |=> (phase_r == PH_IDLE))
    else $error("sequencer not idle after done");
`endif

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the i2c register access master
// Drives half-bit ticks with a slave model that acks, stretches or withholds
// acknowledges and returns random read data, predicts every tick's bus levels
// and status in a scoreboard, and walks through several register settings.
// ----------------------------------------------------------------------------
module tb;
  import i2cra_pkg::*;

  localparam logic [1:0] FUNC_SPARE = 2'd3;
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         PHASE_TICKS = 20;

  typedef enum int {
    PLAN_RANDOM,
    PLAN_ACK_NOW,
    PLAN_ACK_LAST,
    PLAN_NO_ACK
  } ack_plan_t;

  // scoreboard: tick-level model of the master and its expected levels
  class bus_tick_scoreboard;
    logic [7:0] dev_addr;
    logic [7:0] ack_limit;
    phase_t     bus_phase;
    logic [3:0] bit_cnt;
    logic [7:0] shreg;
    logic [1:0] byte_slot;
    logic [7:0] wait_cnt;
    logic [7:0] hold_reg;
    logic [7:0] hold_val;
    bit         rd_op;
    logic [7:0] rx_byte;
    bit         ack_lost;
    res_t       expected_levels[$];
    int         mismatches;
    int         ticks;
    int         wr_done;
    int         rd_done;
    int         nack_done;

    function new();
      dev_addr  = DEV_ADDR_RST;
      ack_limit = ACK_LIMIT_RST;
      bus_phase = PH_IDLE;
      bit_cnt   = '0;
      shreg     = '0;
      byte_slot = BYTE_DEV;
      wait_cnt  = '0;
      hold_reg  = '0;
      hold_val  = '0;
      rd_op     = 1'b0;
      rx_byte   = '0;
      ack_lost  = 1'b0;
    endfunction

    function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [7:0] val);
      if (idx == CFG_DEV_ADDR) dev_addr = val;
      else if (idx == CFG_ACK_LIMIT) ack_limit = val;
    endfunction

    // pick the next byte or phase once a byte has been acknowledged
    function void next_byte();
      if (byte_slot == BYTE_DEV) begin
        shreg     = hold_reg;
        byte_slot = BYTE_REG;
        bit_cnt   = '0;
        bus_phase = PH_BIT_L;
      end else if (byte_slot == BYTE_REG) begin
        if (rd_op) begin
          bus_phase = PH_RS_L;
        end else begin
          shreg     = hold_val;
          byte_slot = BYTE_LAST;
          bit_cnt   = '0;
          bus_phase = PH_BIT_L;
        end
      end else begin
        bit_cnt = '0;
        if (rd_op) begin
          shreg     = '0;
          bus_phase = PH_RD_L;
        end else begin
          bus_phase = PH_STOP_L;
        end
      end
    endfunction

    // advance one tick and queue the levels it should produce
    function void note_tick(item_t it);
      res_t       r;
      logic [1:0] f;
      f = it.kind;
      r = '0;
      r.scl_level = 1'b1;
      r.sda_drive = 1'b1;
      r.sda_level = 1'b1;
      r.busy_res  = 1'b1;
      ticks++;

      // command only taken while idle
      if (bus_phase == PH_IDLE && (f == CMD_WRITE || f == CMD_READ)) begin
        hold_reg  = it.reg_addr;
        hold_val  = it.write_value;
        rd_op     = (f == CMD_READ);
        shreg     = dev_addr;
        byte_slot = BYTE_DEV;
        bit_cnt   = '0;
        wait_cnt  = '0;
        ack_lost  = 1'b0;
        bus_phase = PH_START_H;
      end

      case (bus_phase)
        PH_START_H: begin
          r.sda_level = 1'b0;
          bus_phase = PH_START_L;
        end
        PH_START_L: begin
          r.scl_level = 1'b0;
          r.sda_level = 1'b0;
          bit_cnt = '0;
          bus_phase = PH_BIT_L;
        end
        PH_BIT_L: begin
          r.scl_level = 1'b0;
          r.sda_level = shreg[7];
          bus_phase = PH_BIT_H;
        end
        PH_BIT_H: begin
          r.sda_level = shreg[7];
          shreg = shreg << 1;
          bit_cnt = bit_cnt + 4'd1;
          bus_phase = (bit_cnt >= 4'd8) ? PH_ACK_L : PH_BIT_L;
        end
        PH_ACK_L: begin
          r.scl_level = 1'b0;
          r.sda_drive = 1'b0;
          r.sda_level = 1'b0;
          wait_cnt = '0;
          bus_phase = PH_ACK_H;
        end
        PH_ACK_H: begin
          r.sda_drive = 1'b0;
          r.sda_level = 1'b0;
          if (it.sda_in == 1'b0) begin
            next_byte();
          end else if (wait_cnt >= ack_limit) begin
            ack_lost = 1'b1;
            bus_phase = PH_STOP_L;
          end else begin
            wait_cnt = wait_cnt + 8'd1;
          end
        end
        PH_RS_L: begin
          r.scl_level = 1'b0;
          bus_phase = PH_RS_H;
        end
        PH_RS_H: begin
          shreg = dev_addr + 8'd1;
          byte_slot = BYTE_LAST;
          bus_phase = PH_START_H;
        end
        PH_RD_L: begin
          r.scl_level = 1'b0;
          r.sda_drive = 1'b0;
          r.sda_level = 1'b0;
          bus_phase = PH_RD_H;
        end
        PH_RD_H: begin
          r.sda_drive = 1'b0;
          r.sda_level = 1'b0;
          shreg = {shreg[6:0], it.sda_in};
          bit_cnt = bit_cnt + 4'd1;
          bus_phase = (bit_cnt >= 4'd8) ? PH_NACK_L : PH_RD_L;
        end
        PH_NACK_L: begin
          r.scl_level = 1'b0;
          bus_phase = PH_NACK_H;
        end
        PH_NACK_H: begin
          bus_phase = PH_STOP_L;
        end
        PH_STOP_L: begin
          r.scl_level = 1'b0;
          r.sda_level = 1'b0;
          bus_phase = PH_STOP_H;
        end
        PH_STOP_H: begin
          r.sda_level = 1'b0;
          bus_phase = PH_STOP_END;
        end
        PH_STOP_END: begin
          r.done_res = 1'b1;
          r.status   = ack_lost;
          if (ack_lost) nack_done++;
          else if (rd_op) rd_done++;
          else wr_done++;
          if (!ack_lost && rd_op) rx_byte = shreg;
          bus_phase = PH_IDLE;
        end
        default: begin
          bus_phase = PH_IDLE;
          r.busy_res = 1'b0;
        end
      endcase

      r.read_value = rx_byte;
      expected_levels.push_back(r);
    endfunction

    // compare one result transaction with the oldest expectation
    function void check_levels(logic [OUT_TDATA_W-1:0] tdata);
      res_t got;
      res_t exp_r;
      got = res_t'(tdata[$bits(res_t)-1:0]);
      if (expected_levels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result transaction: %h", tdata);
        return;
      end
      exp_r = expected_levels.pop_front();
      if (got.scl_level !== exp_r.scl_level || got.sda_drive !== exp_r.sda_drive ||
          got.sda_level !== exp_r.sda_level || got.busy_res !== exp_r.busy_res ||
          got.done_res !== exp_r.done_res || got.status !== exp_r.status ||
          got.read_value !== exp_r.read_value) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch at %0t: exp %b%b%b%b%b%b %h got %b%b%b%b%b%b %h",
                   $realtime,
                   exp_r.scl_level, exp_r.sda_drive, exp_r.sda_level, exp_r.busy_res,
                   exp_r.done_res, exp_r.status, exp_r.read_value,
                   got.scl_level, got.sda_drive, got.sda_level, got.busy_res,
                   got.done_res, got.status, got.read_value);
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [IN_TUSER_W-1:0]  in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  bus_tick_scoreboard sb = new();
  ack_plan_t          ack_plan = PLAN_RANDOM;
  int                 ack_hold = 0;
  int                 settings_run = 0;

  i2c_register_access_master u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // slave side: how many high ticks to hold before pulling sda low for ack
  function int ack_delay();
    int pick;
    if (ack_plan == PLAN_ACK_NOW) return 0;
    // longest tolerated wait on the first ack, the rest come at once
    if (ack_plan == PLAN_ACK_LAST) begin
      ack_plan = PLAN_ACK_NOW;
      return int'(sb.ack_limit);
    end
    if (ack_plan == PLAN_NO_ACK) return 1000;
    pick = $urandom_range(0, 19);
    if (pick < 16) return 0;
    if (pick == 16) return $urandom_range(1, int'(sb.ack_limit) + 1);
    if (pick == 17) return int'(sb.ack_limit);
    if (pick == 18) return int'(sb.ack_limit) + 1;
    return 1000;
  endfunction

  // build the next tick from the predicted bus phase
  function item_t next_tick(bit allow_cmd);
    item_t      it;
    int         pick;
    logic [1:0] f;
    it.reg_addr    = 8'($urandom);
    it.write_value = 8'($urandom);
    it.sda_in      = 1'($urandom_range(0, 1));
    if (sb.bus_phase == PH_IDLE) begin
      pick = $urandom_range(0, 9);
      if (allow_cmd && pick < 4) f = FUNC_WRITE;
      else if (allow_cmd && pick < 8) f = FUNC_READ;
      else if (pick % 2 == 0) f = CMD_TICK;
      else f = FUNC_SPARE;
    end else begin
      // occasional command while busy, which must be ignored
      f = ($urandom_range(0, 15) == 0) ? 2'($urandom_range(1, 3)) : CMD_TICK;
    end
    it.kind = cmd_t'(f);
    if (sb.bus_phase == PH_ACK_L) ack_hold = ack_delay();
    if (sb.bus_phase == PH_ACK_H) begin
      it.sda_in = (ack_hold > 0);
      if (ack_hold > 0) ack_hold--;
    end
    return it;
  endfunction

  // offer one tick and wait for its transaction
  task send_tick(input item_t it);
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, it.sda_in, it.write_value, it.reg_addr};
    in_tuser  <= it.kind;
    do @(posedge clk); while (!in_tready);
    sb.note_tick(it);
  endtask

  // random ticks in bursts until the quota is met and the bus is idle again
  task run_ticks(input int quota, input bit with_gaps);
    int sent;
    int burst;
    sent  = 0;
    burst = with_gaps ? $urandom_range(1, 30) : quota + 1;
    while (sent < quota || sb.bus_phase != PH_IDLE) begin
      send_tick(next_tick(sent < quota));
      sent++;
      burst--;
      if (burst == 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst = $urandom_range(1, 30);
      end
    end
    in_tvalid <= 1'b0;
  endtask

  // one full command with a fixed acknowledge behavior
  task run_command(input logic [1:0] f, input logic [7:0] ra, input logic [7:0] wv,
                   input ack_plan_t plan);
    item_t it;
    ack_plan = plan;
    it.kind = cmd_t'(f);
    it.reg_addr = ra;
    it.write_value = wv;
    it.sda_in = 1'b1;
    send_tick(it);
    while (sb.bus_phase != PH_IDLE) send_tick(next_tick(1'b0));
    in_tvalid <= 1'b0;
    @(posedge clk);
    ack_plan = PLAN_RANDOM;
  endtask

  // wait until every result is back and the block has gone quiet
  task settle();
    while (sb.expected_levels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  // result monitor
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_levels(out_tdata);
    end
  end

  // receiver: changing ready patterns plus two long hold-offs
  initial begin
    int cyc;
    int hold;
    int mode;
    int long_holds;
    cyc = 0;
    hold = 0;
    mode = 0;
    long_holds = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (hold > 0) begin
        hold--;
        out_tready <= 1'b0;
      end else if (long_holds < 2 && in_tvalid && cyc >= 700 * (long_holds + 1)) begin
        hold = 60;
        long_holds++;
        out_tready <= 1'b0;
      end else begin
        if (cyc % 97 == 0) mode = $urandom_range(0, 3);
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          2: out_tready <= (cyc % 4 != 0);
          default: out_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // watchdog on cycles without any transaction
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we || !rst_n)
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog expired with %0d results outstanding", sb.expected_levels.size());
    $display("== FAIL ==");
    $finish;
  end

  // main sequence
  initial begin
    int dev_tab[8];
    int lim_tab[8];
    int dev_v;
    int lim_v;
    item_t it;
    dev_tab = '{0, 255, 254, 8'h55, 8'hAA, -1, -1, -1};
    lim_tab = '{0, 1, 255, 3, 2, -1, -1, -1};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, spare func, stretched and missing acks
    run_command(FUNC_WRITE, 8'h00, 8'hFF, PLAN_ACK_NOW);
    run_command(FUNC_READ, 8'hFF, 8'h00, PLAN_ACK_NOW);
    run_command(FUNC_WRITE, 8'hFF, 8'h00, PLAN_ACK_NOW);
    it.kind = cmd_t'(FUNC_SPARE);
    it.reg_addr = 8'hFF;
    it.write_value = 8'hFF;
    it.sda_in = 1'b0;
    send_tick(it);
    it.kind = CMD_TICK;
    it.sda_in = 1'b1;
    send_tick(it);
    in_tvalid <= 1'b0;
    @(posedge clk);
    run_command(FUNC_WRITE, 8'hA5, 8'h5A, PLAN_ACK_LAST);
    run_command(FUNC_READ, 8'h3C, 8'hC3, PLAN_NO_ACK);
    settle();

    // random phases, one register setting each
    for (int p = 0; p < 8; p++) begin
      dev_v = (dev_tab[p] < 0) ? $urandom_range(0, 255) : dev_tab[p];
      lim_v = (lim_tab[p] < 0) ? $urandom_range(0, 6) : lim_tab[p];
      write_reg(CFG_DEV_ADDR, 8'(dev_v));
      write_reg(CFG_ACK_LIMIT, 8'(lim_v));
      settings_run++;
      run_command(FUNC_READ, 8'($urandom), 8'($urandom), PLAN_ACK_NOW);
      run_ticks(PHASE_TICKS, p % 2 == 1);
      settle();
    end

    repeat (10) @(posedge clk);
    if (sb.expected_levels.size() != 0) sb.mismatches++;
    $display("ran %0d ticks over %0d register settings", sb.ticks, settings_run);
    $display("finished %0d writes, %0d reads, %0d missing acks; %0d mismatches",
             sb.wr_done, sb.rd_done, sb.nack_done, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
